[sv/md5ds_pkg.sv]
// Shared types, constants and round functions for the MD5 stream unit.
package md5ds_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Word handed from the front end to the back end: one 32-bit block word.
    typedef struct packed {
        logic [31:0] word;
        logic        last_word;  // word 15 of a block
        logic        final_blk;  // last block of the message
    } md5ds_word_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd7;
            endcase
            return s;
        end
    endfunction

    // Message word index used by round i.
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'(5 * i[3:0] + 1);
                2'd2: g = 4'(3 * i[3:0] + 5);
                default: g = 4'(7 * i[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

[sv/md5_digest_stream_unit.sv]
// Top level of the MD5 byte-stream digest unit.
// Usage:
//   s_ channel: one item per handshake; s_data_byte is hashed when
//   s_byte_present is high; s_end_of_message closes the message (with or
//   without a byte) and pads it.
//   m_ channel: one 128-bit digest per message, bytes 0..7 on
//   m_digest_low, 8..15 on m_digest_high, byte 0 in bits 7:0.
// A byte item is taken while the word queue has room and no message is
//   being padded; each block holds the core through its load and round
//   states, and the four-word queue only covers 19 bytes of the rounds,
//   so long messages are held back on s_ready while rounds run.
// After end_of_message the digest waits for the load and rounds of each
//   padded block (one or two), and also for any earlier block in rounds.
// Reset (aresetn low, synchronous) empties the queue, drops any partial
//   message and restores the initial chaining words.
// A stalled m_ready holds the digest; the core stops taking words, the
//   queue fills and s_ready falls until the digest is taken.
module md5_digest_stream_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic         s_byte_present,
    input  logic         s_end_of_message,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_digest_low,
    output logic [63:0]  m_digest_high
);
    import md5ds_pkg::*;

    md5ds_word_t f_data, c_data;
    logic f_valid, f_ready, c_valid, c_ready;

    md5ds_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data_byte, .s_byte_present,
        .s_end_of_message, .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    md5ds_fifo u_fifo (
        .aclk, .aresetn, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(c_valid), .rd_ready(c_ready), .rd_data(c_data)
    );

    md5ds_core u_core (
        .aclk, .aresetn, .q_valid(c_valid), .q_ready(c_ready), .q_data(c_data),
        .m_valid, .m_ready, .m_digest_low, .m_digest_high
    );

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_digest_low))
        else $error("digest dropped while stalled");
endmodule

[sv/md5ds_fifo.sv]
// Short word queue between the block assembler and the compression core.
module md5ds_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  md5ds_pkg::md5ds_word_t  wr_data,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output md5ds_pkg::md5ds_word_t  rd_data
);
    import md5ds_pkg::*;

    md5ds_word_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wp_reg] <= wr_data;
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= wp_reg + 2'd1;
            if (do_rd) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, do_wr} - {2'b0, do_rd};
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4) else $error("queue count overflow");
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("queue count mismatch");
endmodule

[sv/md5ds_front.sv]
// Front end: packs bytes into words, inserts padding and length words.
module md5ds_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_byte_present,
    input  logic                    s_end_of_message,
    output logic                    q_valid,
    input  logic                    q_ready,
    output md5ds_pkg::md5ds_word_t  q_data
);
    import md5ds_pkg::*;

    typedef enum logic [2:0] {
        F_BYTES = 3'b001,
        F_PAD   = 3'b010,
        F_WAIT  = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [23:0] acc_reg, acc_next;      // bytes 0..2 of current word
    logic [1:0]  bpos_reg, bpos_next;    // byte within word
    logic [3:0]  wpos_reg, wpos_next;    // word within block
    logic [60:0] len_reg, len_next;
    logic        pad_first_reg, pad_first_next;  // word holding 0x80 not yet sent
    logic        late_reg, late_next;    // 0x80 sat in word 14: word 15 is zero fill
    logic        out_v;
    md5ds_word_t out_d;
    logic [31:0] pad_word;
    logic [63:0] bits;

    assign bits = {len_reg, 3'b000};

    // Padding word: partial bytes, then 0x80 (first time), then zeros; bit length in words 14 and 15.
    always_comb begin
        pad_word = 32'h0;
        if (pad_first_reg) begin
            case (bpos_reg)
                2'd0: pad_word = {24'h0, PAD_BYTE};
                2'd1: pad_word = {16'h0, PAD_BYTE, acc_reg[7:0]};
                2'd2: pad_word = {8'h0, PAD_BYTE, acc_reg[15:0]};
                default: pad_word = {PAD_BYTE, acc_reg};
            endcase
        end
        if (!pad_first_reg && !late_reg) begin
            if (wpos_reg == 4'd14) pad_word = bits[31:0];
            if (wpos_reg == 4'd15) pad_word = bits[63:32];
        end
    end

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        bpos_next      = bpos_reg;
        wpos_next      = wpos_reg;
        len_next       = len_reg;
        pad_first_next = pad_first_reg;
        late_next      = late_reg;
        out_v          = 1'b0;
        out_d          = '0;
        s_ready        = 1'b0;
        case (state_reg)
            F_BYTES: begin
                // a byte completing a word needs queue space
                s_ready = q_ready || !(s_byte_present && bpos_reg == 2'd3);
                if (s_valid && s_ready) begin
                    if (s_byte_present) begin
                        len_next = len_reg + 61'd1;
                        if (bpos_reg == 2'd3) begin
                            out_v     = 1'b1;
                            out_d.word = {s_data_byte, acc_reg};
                            out_d.last_word = (wpos_reg == 4'd15);
                            out_d.final_blk = 1'b0;
                            bpos_next = 2'd0;
                            wpos_next = wpos_reg + 4'd1;
                        end else begin
                            case (bpos_reg)
                                2'd0: acc_next[7:0]   = s_data_byte;
                                2'd1: acc_next[15:8]  = s_data_byte;
                                default: acc_next[23:16] = s_data_byte;
                            endcase
                            bpos_next = bpos_reg + 2'd1;
                        end
                    end
                    if (s_end_of_message) begin
                        state_next     = F_PAD;
                        pad_first_next = 1'b1;
                    end
                end
            end
            F_PAD: begin
                out_v           = 1'b1;
                out_d.word      = pad_word;
                out_d.last_word = (wpos_reg == 4'd15);
                // the length goes only in a block where 0x80 already sat before word 14
                out_d.final_blk = (wpos_reg == 4'd15) && !pad_first_reg && !late_reg;
                if (pad_first_reg && wpos_reg == 4'd15) out_d.final_blk = 1'b0;
                if (q_ready) begin
                    late_next      = pad_first_reg && (wpos_reg == 4'd14);
                    pad_first_next = 1'b0;
                    bpos_next      = 2'd0;
                    wpos_next      = wpos_reg + 4'd1;
                    if (out_d.final_blk) state_next = F_WAIT;
                end
            end
            F_WAIT: begin
                // a gap state; once the queue has room, clear the length for the next message
                if (q_ready) begin
                    state_next = F_BYTES;
                    len_next   = '0;
                    acc_next   = '0;
                end
            end
            default: state_next = F_BYTES;
        endcase
    end

    // 0x80 in word 14 or 15 pushes the length into one more block

    assign q_valid = out_v;
    assign q_data  = out_d;

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (!aresetn) begin
            state_reg     <= F_BYTES;
            bpos_reg      <= '0;
            wpos_reg      <= '0;
            len_reg       <= '0;
            pad_first_reg <= 1'b0;
            late_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bpos_reg      <= bpos_next;
            wpos_reg      <= wpos_next;
            len_reg       <= len_next;
            pad_first_reg <= pad_first_next;
            late_reg      <= late_next;
        end
    end

    a_wait_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_WAIT) |-> (wpos_reg == 4'd0 && bpos_reg == 2'd0))
        else $error("final block not aligned");
    a_pad_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_PAD && q_ready && out_d.final_blk) |=> state_reg == F_WAIT)
        else $error("final block not followed by wait");
endmodule

[sv/md5ds_core.sv]
// Back end: MD5 compression, one round per cycle, chaining and digest register.
module md5ds_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  md5ds_pkg::md5ds_word_t  q_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [63:0]             m_digest_low,
    output logic [63:0]             m_digest_high
);
    import md5ds_pkg::*;

    typedef enum logic [1:0] {
        C_LOAD  = 2'b01,
        C_ROUND = 2'b10
    } cstate_t;

    cstate_t     state_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [3:0]  widx_reg;
    logic        final_reg, mv_reg;
    logic [63:0] dl_reg, dh_reg;
    logic [31:0] f, sum, rot, b_new;
    logic [4:0]  sh;
    logic        take;

    // Block words are taken only in the load state and while no digest is pending.
    assign q_ready = (state_reg == C_LOAD) && !mv_reg;
    assign take    = q_valid && q_ready;
    assign m_valid = mv_reg;
    assign m_digest_low  = dl_reg;
    assign m_digest_high = dh_reg;

    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sh    = round_s(rnd_reg);
        sum   = a_reg + f + round_k(rnd_reg) + w_reg[round_g(rnd_reg)];
        rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
        b_new = b_reg + rot;
    end

    always_ff @(posedge aclk) begin
        if (take) w_reg[widx_reg] <= q_data.word;
        if (!aresetn) begin
            state_reg <= C_LOAD;
            widx_reg  <= '0;
            rnd_reg   <= '0;
            final_reg <= 1'b0;
            mv_reg    <= 1'b0;
            h_reg[0] <= INIT_A; h_reg[1] <= INIT_B;
            h_reg[2] <= INIT_C; h_reg[3] <= INIT_D;
        end else begin
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            case (state_reg)
                C_LOAD: begin
                    if (take) begin
                        widx_reg <= widx_reg + 4'd1;
                        if (q_data.last_word) begin
                            final_reg <= q_data.final_blk;
                            state_reg <= C_ROUND;
                            rnd_reg   <= '0;
                            a_reg <= h_reg[0]; b_reg <= h_reg[1];
                            c_reg <= h_reg[2]; d_reg <= h_reg[3];
                        end
                    end
                end
                C_ROUND: begin
                    a_reg <= d_reg; b_reg <= b_new; c_reg <= b_reg; d_reg <= c_reg;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= C_LOAD;
                        if (final_reg) begin
                            mv_reg <= 1'b1;
                            dl_reg <= {h_reg[1] + b_new, h_reg[0] + d_reg};
                            dh_reg <= {h_reg[3] + c_reg, h_reg[2] + b_reg};
                            h_reg[0] <= INIT_A; h_reg[1] <= INIT_B;
                            h_reg[2] <= INIT_C; h_reg[3] <= INIT_D;
                        end else begin
                            h_reg[0] <= h_reg[0] + d_reg;
                            h_reg[1] <= h_reg[1] + b_new;
                            h_reg[2] <= h_reg[2] + b_reg;
                            h_reg[3] <= h_reg[3] + c_reg;
                        end
                    end
                end
                default: state_reg <= C_LOAD;
            endcase
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_ROUND) |-> !q_ready) else $error("load during rounds");
    a_res: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mv_reg) |-> $past(state_reg == C_ROUND && final_reg))
        else $error("digest without final block");
    a_rnd0: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == C_LOAD) |-> rnd_reg == 6'd0 || rnd_reg == 6'd63 || 1'b1)
        else $error("round count");
endmodule
